>>> src/cadtp_pkg.sv
// Shared types and constants for the comment-aware decimal token parser.
// Depends on nothing; every other file but cadtp_fifo imports it.
package cadtp_pkg;

	localparam int unsigned MID_DEPTH = 4;
	localparam int unsigned OUT_DEPTH = 2;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_VT    = 8'h0B;
	localparam logic [7:0] CH_FF    = 8'h0C;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_RBRACE = 8'h7D;

	typedef enum logic [3:0] {
		CL_OTHER,
		CL_DIGIT,
		CL_PLUS,
		CL_MINUS,
		CL_VTFF,
		CL_HASH,
		CL_NEWLINE,
		CL_BLANK,
		CL_NUL
	} cls_t;

	typedef struct packed {
		cls_t       cls;
		logic [3:0] digit;
	} tok_t;

	typedef struct packed {
		logic signed [31:0] value;
		logic               has_digits;
	} result_t;

	typedef enum logic [1:0] {
		PH_SKIP,
		PH_COMMENT,
		PH_LEAD,
		PH_NUMBER
	} phase_t;

endpackage

>>> src/comment_aware_decimal_token_parser.sv
// Top level of the comment-aware decimal token parser.
// Depends on cadtp_pkg, cadtp_fifo, cadtp_classify and cadtp_exec.
//
// Usage:
//   Input side is a queue: drive data_byte and push; a byte is taken at
//   each rising edge with push high and full low. One text byte per request.
//   Result side is a queue: while empty is low, token_value and has_digits
//   show the oldest finished token; pulse pop to take it.
//   Each byte is classified on entry and written into a short queue; the
//   back end takes one classified byte per cycle while the result queue
//   has room, accumulating the value with a shift-add multiply by ten,
//   and writes one result per finished token into a two-entry result queue.
//   Throughput: one byte per cycle, sustained, while pop keeps up.
//   A token's closing byte is registered in the byte queue; the back end
//   then writes its result into the result queue, which drives the ports.
//   When the receiver stalls, the result queue fills, the back end halts,
//   then the byte queue fills and full rises; nothing is dropped.
//   Reset clears both queues and puts the parser in the between-tokens
//   state; the block accepts bytes in the first cycle after reset.
module comment_aware_decimal_token_parser #(
	parameter int unsigned MidDepth = cadtp_pkg::MID_DEPTH,
	parameter int unsigned OutDepth = cadtp_pkg::OUT_DEPTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic [7:0]         data_byte,
	output logic               empty,
	input  logic               pop,
	output logic signed [31:0] token_value,
	output logic               has_digits
);
	import cadtp_pkg::*;

	tok_t    in_tok, mid_tok;
	result_t res_in, res_out;
	logic    mid_empty, mid_pop, out_full, out_push;

	cadtp_classify u_classify (
		.data_byte (data_byte),
		.tok       (in_tok)
	);

	cadtp_fifo #(
		.Width ($bits(tok_t)),
		.Depth (MidDepth)
	) u_mid_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (in_tok),
		.full   (full),
		.pop    (mid_pop),
		.rdata  (mid_tok),
		.empty  (mid_empty)
	);

	cadtp_exec u_exec (
		.clk       (clk),
		.arst_n    (arst_n),
		.tok       (mid_tok),
		.tok_valid (!mid_empty),
		.tok_pop   (mid_pop),
		.res_full  (out_full),
		.res_push  (out_push),
		.res       (res_in)
	);

	cadtp_fifo #(
		.Width ($bits(result_t)),
		.Depth (OutDepth)
	) u_out_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (out_push),
		.wdata  (res_in),
		.full   (out_full),
		.pop    (pop),
		.rdata  (res_out),
		.empty  (empty)
	);

	assign token_value = res_out.value;
	assign has_digits  = res_out.has_digits;

	a_pop_needs_data: assert property (@(posedge clk) disable iff (!arst_n)
		mid_pop |-> !mid_empty)
		else $error("back end popped an empty byte queue");

	a_result_from_byte: assert property (@(posedge clk) disable iff (!arst_n)
		out_push |-> (mid_pop && !out_full))
		else $error("result written without consuming a byte");

	a_back_no_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(!mid_empty && !out_full) |-> mid_pop)
		else $error("back end idle with work and room");

	a_no_digits_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_push && !res_in.has_digits) |-> (res_in.value == 32'sd0))
		else $error("token without digits carries a nonzero value");
endmodule

>>> src/cadtp_fifo.sv
// Small first-in first-out queue in flip-flops, used between front and back
// and on the result side. Depends on nothing.
module cadtp_fifo #(
	parameter int unsigned Width = 8,
	parameter int unsigned Depth = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [Width-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [Width-1:0] rdata,
	output logic             empty
);
	localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int unsigned CW = $clog2(Depth + 1);

	logic [Width-1:0] mem_q [Depth];
	logic [AW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push, do_pop;

	assign full    = (count_q == CW'(Depth));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end
endmodule

>>> src/cadtp_classify.sv
// Front part: sorts each incoming byte into a class and extracts its digit.
// Depends on cadtp_pkg.
module cadtp_classify (
	input  logic [7:0]     data_byte,
	output cadtp_pkg::tok_t tok
);
	import cadtp_pkg::*;

	always_comb begin
		tok.digit = data_byte[3:0];
		if (data_byte >= CH_ZERO && data_byte <= CH_NINE) begin
			tok.cls = CL_DIGIT;
		end else if (data_byte == CH_CR || data_byte == CH_LF) begin
			tok.cls = CL_NEWLINE;
		end else if (data_byte == CH_TAB || data_byte == CH_SPACE ||
		             data_byte == CH_LBRACE || data_byte == CH_RBRACE) begin
			tok.cls = CL_BLANK;
		end else if (data_byte == CH_HASH) begin
			tok.cls = CL_HASH;
		end else if (data_byte == CH_PLUS) begin
			tok.cls = CL_PLUS;
		end else if (data_byte == CH_MINUS) begin
			tok.cls = CL_MINUS;
		end else if (data_byte == CH_VT || data_byte == CH_FF) begin
			tok.cls = CL_VTFF;
		end else if (data_byte == CH_NUL) begin
			tok.cls = CL_NUL;
		end else begin
			tok.cls = CL_OTHER;
		end
	end
endmodule

>>> src/cadtp_exec.sv
// Back part: runs the token state machine on classified bytes and forms
// the decimal value. Depends on cadtp_pkg.
module cadtp_exec (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cadtp_pkg::tok_t      tok,
	input  logic                 tok_valid,
	output logic                 tok_pop,
	input  logic                 res_full,
	output logic                 res_push,
	output cadtp_pkg::result_t   res
);
	import cadtp_pkg::*;

	phase_t      phase_q, phase_d;
	logic [31:0] acc_q, acc_d;
	logic        neg_q, neg_d;
	logic        seen_q, seen_d;
	logic        stop_q, stop_d;
	logic        adv, is_delim, ends;
	logic [31:0] acc_x10;

	assign adv      = tok_valid && !res_full;
	assign tok_pop  = adv;
	assign is_delim = (tok.cls == CL_HASH) || (tok.cls == CL_NEWLINE) ||
	                  (tok.cls == CL_BLANK);
	assign ends     = is_delim || (tok.cls == CL_NUL);
	assign acc_x10  = (acc_q << 3) + (acc_q << 1);

	always_comb begin
		phase_d = phase_q;
		unique case (phase_q)
			PH_SKIP: begin
				if (tok.cls == CL_HASH) begin
					phase_d = PH_COMMENT;
				end else if (!is_delim) begin
					phase_d = (tok.cls inside {CL_PLUS, CL_MINUS, CL_DIGIT}) ?
					          PH_NUMBER : PH_LEAD;
				end
			end
			PH_COMMENT: begin
				if (tok.cls == CL_NEWLINE) begin
					phase_d = PH_SKIP;
				end
			end
			PH_LEAD, PH_NUMBER: begin
				if (ends) begin
					phase_d = (tok.cls == CL_HASH) ? PH_COMMENT : PH_SKIP;
				end else if (phase_q == PH_LEAD && !stop_q &&
				             tok.cls inside {CL_PLUS, CL_MINUS, CL_DIGIT}) begin
					phase_d = PH_NUMBER;
				end
			end
			default: phase_d = PH_SKIP;
		endcase
	end

	always_comb begin
		acc_d    = acc_q;
		neg_d    = neg_q;
		seen_d   = seen_q;
		stop_d   = stop_q;
		res_push = 1'b0;
		unique case (phase_q)
			PH_SKIP: begin
				if (!is_delim) begin
					acc_d  = '0;
					neg_d  = 1'b0;
					seen_d = 1'b0;
					stop_d = 1'b0;
					case (tok.cls)
						CL_VTFF, CL_PLUS: ;
						CL_MINUS: neg_d = 1'b1;
						CL_DIGIT: begin
							acc_d  = {28'd0, tok.digit};
							seen_d = 1'b1;
						end
						default: stop_d = 1'b1;
					endcase
				end
			end
			PH_COMMENT: ;
			PH_LEAD: begin
				if (ends) begin
					res_push = adv;
				end else if (!stop_q) begin
					case (tok.cls)
						CL_VTFF: ;
						CL_PLUS:  neg_d = 1'b0;
						CL_MINUS: neg_d = 1'b1;
						CL_DIGIT: begin
							acc_d  = {28'd0, tok.digit};
							seen_d = 1'b1;
						end
						default: stop_d = 1'b1;
					endcase
				end
			end
			PH_NUMBER: begin
				if (ends) begin
					res_push = adv;
				end else if (!stop_q) begin
					if (tok.cls == CL_DIGIT) begin
						acc_d  = acc_x10 + {28'd0, tok.digit};
						seen_d = 1'b1;
					end else begin
						stop_d = 1'b1;
					end
				end
			end
			default: ;
		endcase
	end

	always_comb begin
		res.has_digits = seen_q;
		if (!seen_q) begin
			res.value = '0;
		end else if (neg_q) begin
			res.value = $signed(32'd0 - acc_q);
		end else begin
			res.value = $signed(acc_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SKIP;
			acc_q   <= '0;
			neg_q   <= 1'b0;
			seen_q  <= 1'b0;
			stop_q  <= 1'b0;
		end else if (adv) begin
			phase_q <= phase_d;
			acc_q   <= acc_d;
			neg_q   <= neg_d;
			seen_q  <= seen_d;
			stop_q  <= stop_d;
		end
	end
endmodule

>>> tb/sv/tb_comment_aware_decimal_token_parser.sv
// Self-checking testbench for comment_aware_decimal_token_parser: a directed byte table,
// then random token streams, each popped token checked by the table or a parser model.
// Depends on cadtp_pkg and the parser RTL only.
module tb_comment_aware_decimal_token_parser;
	timeunit 1ns;
	timeprecision 1ps;

	import cadtp_pkg::*;

	localparam int unsigned CYCLE_LIMIT  = 200000;
	localparam int unsigned RANDOM_BYTES = 1100;
	localparam int unsigned HOLD_CYCLES  = 60;
	localparam int unsigned DRAIN_CYCLES = 8;

	typedef struct {
		logic [7:0]         data;
		bit                 fixed;
		logic signed [31:0] value;
		logic               has_digits;
	} byte_req_t;

	logic               clk;
	logic               arst_n;
	logic               push;
	logic               full;
	logic [7:0]         data_byte;
	logic               empty;
	logic               pop;
	logic signed [31:0] token_value;
	logic               has_digits;

	byte_req_t   byte_stream[$];
	byte_req_t   cur_req;
	result_t     pending_tokens[$];
	result_t     model_tok;
	result_t     want_tok;
	bit          model_fires;
	int unsigned sent_count;
	int unsigned send_idle_pct;
	int unsigned recv_idle_pct;
	int unsigned cycle_count;
	int unsigned error_count;

	phase_t      parse_phase;
	logic [31:0] parse_mag;
	logic        parse_neg;
	logic        parse_seen;
	logic        parse_done;

	comment_aware_decimal_token_parser dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.data_byte  (data_byte),
		.empty      (empty),
		.pop        (pop),
		.token_value(token_value),
		.has_digits (has_digits)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic bit is_delim(input logic [7:0] b);
		return b inside {CH_CR, CH_LF, CH_TAB, CH_SPACE, CH_HASH, CH_LBRACE, CH_RBRACE};
	endfunction

	function automatic bit is_digit(input logic [7:0] b);
		return b >= CH_ZERO && b <= CH_NINE;
	endfunction

	function automatic void take_number_byte(input logic [7:0] b);
		if (parse_done)
			return;
		if (parse_phase == PH_LEAD) begin
			if (b == CH_VT || b == CH_FF) begin
			end else if (b == CH_PLUS || b == CH_MINUS) begin
				parse_neg   = (b == CH_MINUS);
				parse_phase = PH_NUMBER;
			end else if (is_digit(b)) begin
				parse_mag   = 32'(b - CH_ZERO);
				parse_seen  = 1'b1;
				parse_phase = PH_NUMBER;
			end else begin
				parse_done = 1'b1;
			end
		end else if (is_digit(b)) begin
			parse_mag  = parse_mag * 32'd10 + 32'(b - CH_ZERO);
			parse_seen = 1'b1;
		end else begin
			parse_done = 1'b1;
		end
	endfunction

	function automatic result_t finished_token();
		result_t r;
		r.value      = !parse_seen ? 32'sd0 : parse_neg ? 32'(32'd0 - parse_mag) : parse_mag;
		r.has_digits = parse_seen;
		return r;
	endfunction

	// advance the parser model by one byte; returns 1 when a token closes
	function automatic bit parse_byte(input logic [7:0] b, output result_t tok);
		tok = '0;
		case (parse_phase)
			PH_SKIP: begin
				if (b == CH_HASH) begin
					parse_phase = PH_COMMENT;
				end else if (!is_delim(b)) begin
					parse_mag   = '0;
					parse_neg   = 1'b0;
					parse_seen  = 1'b0;
					parse_done  = 1'b0;
					parse_phase = PH_LEAD;
					if (b == CH_NUL)
						parse_done = 1'b1;
					else
						take_number_byte(b);
				end
				return 1'b0;
			end
			PH_COMMENT: begin
				if (b == CH_CR || b == CH_LF)
					parse_phase = PH_SKIP;
				return 1'b0;
			end
			default: begin
				if (is_delim(b) || b == CH_NUL) begin
					tok         = finished_token();
					parse_phase = (b == CH_HASH) ? PH_COMMENT : PH_SKIP;
					return 1'b1;
				end
				take_number_byte(b);
				return 1'b0;
			end
		endcase
	endfunction

	task automatic add_byte(input logic [7:0] b);
		byte_stream.push_back('{b, 1'b0, 32'sd0, 1'b0});
	endtask

	function automatic logic [7:0] pick_blank();
		logic [7:0] blanks[6] = '{CH_SPACE, CH_TAB, CH_CR, CH_LF, CH_LBRACE, CH_RBRACE};
		return blanks[$urandom_range(5)];
	endfunction

	task automatic build_random_stream();
		int unsigned start_len;
		int unsigned n;
		logic [7:0]  b;
		start_len = byte_stream.size();
		while (byte_stream.size() - start_len < RANDOM_BYTES) begin
			if ($urandom_range(99) < 10) begin
				repeat ($urandom_range(1, 4)) add_byte(8'($urandom_range(255)));
				continue;
			end
			repeat ($urandom_range(1, 2)) add_byte(pick_blank());
			if ($urandom_range(99) < 12) begin
				add_byte(CH_HASH);
				repeat ($urandom_range(0, 5)) begin
					do b = 8'($urandom_range(255)); while (b == CH_CR || b == CH_LF);
					add_byte(b);
				end
				add_byte($urandom_range(1) ? CH_CR : CH_LF);
			end
			if ($urandom_range(99) < 8)
				add_byte(CH_NUL);
			if ($urandom_range(99) < 15)
				repeat ($urandom_range(1, 2)) add_byte($urandom_range(1) ? CH_VT : CH_FF);
			if ($urandom_range(99) < 40)
				add_byte($urandom_range(1) ? CH_MINUS : CH_PLUS);
			n = ($urandom_range(99) < 15) ? $urandom_range(10, 12) : $urandom_range(0, 5);
			repeat (n) add_byte(8'(CH_ZERO + $urandom_range(9)));
			if ($urandom_range(99) < 15)
				repeat ($urandom_range(1, 3)) add_byte(8'($urandom_range(8'h61, 8'h7A)));
			case ($urandom_range(9))
				0: add_byte(CH_NUL);
				1: add_byte(CH_HASH);
				default: add_byte(pick_blank());
			endcase
		end
	endtask

	task automatic send_request(input byte_req_t req);
		bit taken;
		taken = 1'b0;
		while ($urandom_range(99) < send_idle_pct) begin
			push <= 1'b0;
			@(negedge clk);
		end
		push      <= 1'b1;
		data_byte <= req.data;
		cur_req   <= req;
		do begin
			@(posedge clk);
			taken = !full;
			@(negedge clk);
		end while (!taken);
		sent_count++;
	endtask

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (push && !full) begin
				model_fires = parse_byte(data_byte, model_tok);
				if (cur_req.fixed)
					pending_tokens.push_back('{cur_req.value, cur_req.has_digits});
				else if (model_fires)
					pending_tokens.push_back(model_tok);
			end
			if (pop && !empty) begin
				if (pending_tokens.size() == 0) begin
					$error("token_value: expected none, actual %0d", token_value);
					error_count++;
				end else begin
					want_tok = pending_tokens.pop_front();
					if (token_value !== want_tok.value) begin
						$error("token_value: expected %0d, actual %0d", want_tok.value, token_value);
						error_count++;
					end
					if (has_digits !== want_tok.has_digits) begin
						$error("has_digits: expected %0b, actual %0b",
							want_tok.has_digits, has_digits);
						error_count++;
					end
				end
			end
		end
	end

	// receiver: random pop, with one long hold-off to back up the block
	initial begin
		bit held;
		held = 1'b0;
		pop  = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!held && sent_count >= 150) begin
				held = 1'b1;
				pop <= 1'b0;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
			end else begin
				pop <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	initial begin
		int unsigned total;
		parse_phase   = PH_SKIP;
		parse_mag     = '0;
		parse_neg     = 1'b0;
		parse_seen    = 1'b0;
		parse_done    = 1'b0;
		cycle_count   = 0;
		error_count   = 0;
		sent_count    = 0;
		send_idle_pct = 30;
		recv_idle_pct = 79;
		arst_n        = 1'b0;
		push          = 1'b0;
		data_byte     = '0;
		cur_req       = '{8'h00, 1'b0, 32'sd0, 1'b0};

		byte_stream = '{
			'{CH_MINUS, 0, 0, 0}, '{"5", 0, 0, 0}, '{CH_SPACE, 1, -32'sd5, 1},
			'{CH_HASH, 0, 0, 0}, '{"x", 0, 0, 0}, '{CH_LF, 0, 0, 0},
			'{CH_NUL, 0, 0, 0}, '{"z", 0, 0, 0}, '{CH_RBRACE, 1, 0, 0},
			'{CH_VT, 0, 0, 0}, '{CH_PLUS, 0, 0, 0}, '{"7", 0, 0, 0}, '{CH_NUL, 1, 7, 1},
			'{8'hFF, 0, 0, 0}, '{CH_HASH, 1, 0, 0}, '{CH_CR, 0, 0, 0},
			'{"9", 0, 0, 0}, '{"9", 0, 0, 0}, '{"a", 0, 0, 0}, '{CH_LBRACE, 1, 99, 1},
			'{CH_MINUS, 0, 0, 0}, '{CH_TAB, 1, 0, 0},
			'{CH_FF, 0, 0, 0}, '{"3", 0, 0, 0}, '{CH_CR, 1, 3, 1}
		};
		build_random_stream();
		total = byte_stream.size();

		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (byte_stream[i]) begin
			if (i < total / 3) begin
				send_idle_pct = 30;
				recv_idle_pct = 79;
			end else if (i < 2 * total / 3) begin
				send_idle_pct = 79;
				recv_idle_pct = 30;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			send_request(byte_stream[i]);
		end
		push <= 1'b0;

		while (pending_tokens.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (error_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

>>> comment_aware_decimal_token_parser.f
src/cadtp_pkg.sv
src/cadtp_fifo.sv
src/cadtp_classify.sv
src/cadtp_exec.sv
src/comment_aware_decimal_token_parser.sv
tb/sv/tb_comment_aware_decimal_token_parser.sv
